// ===== rtl/core/assert_macros.svh =====
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ptmc_pkg.sv =====
package ptmc_pkg;

    typedef enum logic [1:0] {
        MODE_POWER = 2'd0,
        MODE_FREQ  = 2'd1,
        MODE_ALARM = 2'd2,
        MODE_ERROR = 2'd3
    } mode_t;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_A    = 2'd1;
    localparam logic [1:0] KEY_B    = 2'd2;
    localparam logic [1:0] KEY_AB   = 2'd3;

    localparam logic [1:0] PRESS_SHORT = 2'd0;
    localparam logic [1:0] PRESS_LONG  = 2'd1;
    localparam logic [1:0] PRESS_VLONG = 2'd2;

    localparam logic [1:0] FREQ_ONE = 2'd1;
    localparam logic [1:0] FREQ_TWO = 2'd2;

    localparam logic [1:0] PERIOD_LEVEL1 = 2'd0;
    localparam logic [1:0] PERIOD_LEVEL2 = 2'd1;
    localparam logic [1:0] PERIOD_CODE   = 2'd2;

    localparam logic [2:0] STEP_START    = 3'd0;
    localparam logic [2:0] STEP_BURST    = 3'd1;
    localparam logic [2:0] STEP_STOP_ARM = 3'd2;
    localparam logic [2:0] STEP_STOP     = 3'd3;
    localparam logic [2:0] STEP_CODE_ARM = 3'd4;
    localparam logic [2:0] STEP_CODE     = 3'd5;

    localparam int         POWER_LEVELS = 32;
    localparam logic [5:0] LEVEL_MAX    = 6'(POWER_LEVELS);

    localparam logic [15:0] L1_ON    = 16'd30;
    localparam logic [15:0] L1_OFF   = 16'd314;
    localparam logic [15:0] L1_CHECK = 16'd200;
    localparam logic [15:0] L1_BURST = 16'd1887;
    localparam logic [15:0] L2_ON    = 16'd46;
    localparam logic [15:0] L2_OFF   = 16'd476;
    localparam logic [15:0] L2_CHECK = 16'd300;
    localparam logic [15:0] L2_BURST = 16'd2899;
    localparam logic [15:0] STOP_TICKS = 16'd330;
    localparam logic [15:0] CODE_TICKS = 16'd66;

    localparam logic [7:0] DRIVE_TABLE [32] = '{
        8'h00, 8'h80, 8'h01, 8'h81, 8'h04, 8'h03, 8'h05, 8'h85,
        8'h08, 8'h88, 8'h10, 8'h90, 8'h11, 8'h91, 8'h14, 8'h8d,
        8'h20, 8'ha0, 8'h18, 8'ha1, 8'h40, 8'hc0, 8'h25, 8'hc1,
        8'h44, 8'hc4, 8'h45, 8'ha9, 8'h31, 8'h31, 8'h31, 8'h31
    };

    typedef struct packed {
        logic       operation;
        logic [1:0] key;
        logic [1:0] press;
        logic       protect_level;
    } ptmc_in_t;

    typedef struct packed {
        logic       signal_switch;
        logic [1:0] mode;
        logic [5:0] power_level;
        logic [7:0] drive_code;
        logic [1:0] freq_level;
        logic [1:0] period_select;
        logic       sending;
    } ptmc_out_t;

    typedef struct packed {
        mode_t       mode;
        logic [5:0]  level;
        logic [1:0]  freq_sel;
        logic [1:0]  freq_active;
        logic        enable;
        logic        send_request;
        logic [2:0]  send_step;
        logic        code_timing;
        logic        safe;
        logic [15:0] tick_count;
        logic        switch_on;
    } ptmc_state_t;

    localparam ptmc_state_t STATE_RESET = '{
        mode:         MODE_POWER,
        level:        6'd1,
        freq_sel:     FREQ_ONE,
        freq_active:  FREQ_ONE,
        enable:       1'b1,
        send_request: 1'b0,
        send_step:    STEP_START,
        code_timing:  1'b0,
        safe:         1'b1,
        tick_count:   16'd0,
        switch_on:    1'b0
    };

    function automatic logic [7:0] drive_lookup(input logic [5:0] level);
        logic [5:0] idx;
        logic [7:0] code;
        idx = level - 6'd1;
        if (level == 6'd0)
        begin
            code = 8'h00;
        end
        else if (idx > 6'd31)
        begin
            code = DRIVE_TABLE[31];
        end
        else
        begin
            code = DRIVE_TABLE[idx[4:0]];
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/ptmc_key_fsm.sv =====
module ptmc_key_fsm
    import ptmc_pkg::*;
(
    input  ptmc_state_t cur,
    input  logic [1:0]  key,
    input  logic [1:0]  press,
    output ptmc_state_t nxt
);

    logic short_a;
    logic short_b;

    assign short_a = (key == KEY_A) && (press == PRESS_SHORT);
    assign short_b = (key == KEY_B) && (press == PRESS_SHORT);

    always_comb
    begin
        nxt = cur;
        case (cur.mode)
            MODE_POWER:
            begin
                if (key == KEY_AB)
                begin
                    if (press == PRESS_LONG)
                    begin
                        nxt.mode = MODE_ALARM;
                    end
                    else if (press == PRESS_VLONG)
                    begin
                        nxt.mode = MODE_FREQ;
                    end
                end
                else if (short_a)
                begin
                    if (cur.level < LEVEL_MAX)
                    begin
                        nxt.enable = 1'b1;
                        nxt.level  = cur.level + 6'd1;
                    end
                end
                else if (short_b)
                begin
                    if (cur.level != 6'd0)
                    begin
                        nxt.level = cur.level - 6'd1;
                        if (cur.level == 6'd1)
                        begin
                            nxt.enable = 1'b0;
                        end
                    end
                end
            end
            MODE_FREQ:
            begin
                if (short_a)
                begin
                    nxt.freq_sel = (cur.freq_sel == FREQ_ONE) ? FREQ_TWO : FREQ_ONE;
                end
                else if (short_b)
                begin
                    nxt.mode = MODE_POWER;
                end
            end
            MODE_ALARM:
            begin
                if (short_a)
                begin
                    nxt.send_request = 1'b1;
                end
                else if (short_b)
                begin
                    nxt.mode = MODE_POWER;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== rtl/core/ptmc_pulse_timer.sv =====
module ptmc_pulse_timer
    import ptmc_pkg::*;
(
    input  ptmc_state_t cur,
    input  logic        protect_level,
    output ptmc_state_t nxt
);

    logic [15:0] on_pos;
    logic [15:0] off_pos;
    logic [15:0] check_pos;
    logic [15:0] burst_len;
    logic [15:0] cnt;
    logic [1:0]  active;

    assign active = (cur.tick_count == 16'd0) ? cur.freq_sel : cur.freq_active;

    always_comb
    begin
        on_pos    = '0;
        off_pos   = '0;
        check_pos = '0;
        burst_len = '0;
        if (!cur.code_timing)
        begin
            if (active == FREQ_ONE)
            begin
                on_pos    = L1_ON;
                off_pos   = L1_OFF;
                check_pos = L1_CHECK;
                burst_len = L1_BURST;
            end
            else
            begin
                on_pos    = L2_ON;
                off_pos   = L2_OFF;
                check_pos = L2_CHECK;
                burst_len = L2_BURST;
            end
        end
    end

    always_comb
    begin
        nxt = cur;
        nxt.freq_active = active;
        cnt = cur.tick_count;
        if (!cur.enable)
        begin
            nxt.switch_on  = 1'b0;
            nxt.tick_count = '0;
        end
        else if (cur.mode != MODE_ALARM)
        begin
            // free-running pulse train
            cnt = cur.tick_count + 16'd1;
            if (cnt == on_pos)
            begin
                nxt.switch_on = 1'b0;
            end
            if (cnt == off_pos)
            begin
                cnt = '0;
                nxt.switch_on = 1'b1;
            end
            if (cnt == check_pos)
            begin
                nxt.safe = protect_level;
            end
            nxt.tick_count = cnt;
        end
        else if (!cur.send_request)
        begin
            nxt.switch_on  = 1'b0;
            nxt.tick_count = '0;
            nxt.send_step  = STEP_START;
        end
        else
        begin
            // alarm send sequence
            case (cur.send_step)
                STEP_START, STEP_BURST:
                begin
                    if (cur.send_step == STEP_START)
                    begin
                        nxt.switch_on = 1'b1;
                        nxt.send_step = STEP_BURST;
                    end
                    if (cnt == burst_len)
                    begin
                        cnt = '0;
                        nxt.switch_on   = 1'b0;
                        nxt.send_step   = STEP_STOP_ARM;
                        nxt.code_timing = 1'b1;
                    end
                end
                STEP_STOP_ARM:
                begin
                    nxt.switch_on = 1'b0;
                    nxt.send_step = STEP_STOP;
                    cnt = '0;
                end
                STEP_STOP:
                begin
                    if (cnt == STOP_TICKS)
                    begin
                        nxt.send_step = STEP_CODE_ARM;
                    end
                end
                STEP_CODE_ARM:
                begin
                    nxt.switch_on = 1'b1;
                    nxt.send_step = STEP_CODE;
                    cnt = '0;
                end
                STEP_CODE:
                begin
                    if (cnt == CODE_TICKS)
                    begin
                        cnt = '0;
                        nxt.switch_on    = 1'b0;
                        nxt.send_request = 1'b0;
                        nxt.send_step    = STEP_START;
                        nxt.code_timing  = 1'b0;
                    end
                end
                default:
                begin
                    cnt = cur.tick_count;
                end
            endcase
            nxt.tick_count = cnt + 16'd1;
        end
    end

endmodule

// ===== rtl/core/pulse_transmitter_mode_controller.sv =====
// channel   direction  payload     handshake
// cmd       in         ptmc_in_t   cmd_valid / cmd_ready
// rsp       out        ptmc_out_t  rsp_valid / rsp_ready
//
// one beat per cycle sustained while rsp_ready holds; an accepted cmd beat is held in the cmd
// register, passes the step logic and is loaded into the rsp register, which raises rsp_valid
// reset puts the controller in power set mode at level one, switch off
// a stalled rsp holds the step; once the cmd register is full cmd_ready drops
// a cmd beat is still taken in the cycle the rsp register drains
`include "assert_macros.svh"

module pulse_transmitter_mode_controller
    import ptmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  ptmc_in_t  cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ptmc_out_t rsp
);

    ptmc_in_t    cmd_reg;
    logic        cmd_valid_reg;
    ptmc_out_t   rsp_reg;
    ptmc_out_t   rsp_next;
    logic        rsp_valid_reg;
    ptmc_state_t state_reg;
    ptmc_state_t state_next;
    ptmc_state_t key_state;
    ptmc_state_t tick_state;
    ptmc_state_t stepped;
    logic        step_fire;

    assign step_fire = cmd_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !cmd_valid_reg || step_fire;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ptmc_key_fsm u_key_fsm (
        .cur   (state_reg),
        .key   (cmd_reg.key),
        .press (cmd_reg.press),
        .nxt   (key_state)
    );

    ptmc_pulse_timer u_pulse_timer (
        .cur           (state_reg),
        .protect_level (cmd_reg.protect_level),
        .nxt           (tick_state)
    );

    always_comb
    begin
        stepped    = (cmd_reg.operation == OP_KEY) ? key_state : tick_state;
        state_next = stepped;
        if (!stepped.safe)
        begin
            state_next.mode = MODE_ERROR;
        end
        else if (stepped.mode == MODE_ERROR)
        begin
            state_next.mode = MODE_POWER;
        end

        rsp_next.signal_switch = state_next.switch_on;
        rsp_next.mode          = state_next.mode;
        rsp_next.power_level   = state_next.level;
        rsp_next.drive_code    = drive_lookup(state_next.level);
        rsp_next.freq_level    = state_next.freq_sel;
        if (state_next.code_timing)
        begin
            rsp_next.period_select = PERIOD_CODE;
        end
        else if (state_next.freq_active == FREQ_ONE)
        begin
            rsp_next.period_select = PERIOD_LEVEL1;
        end
        else
        begin
            rsp_next.period_select = PERIOD_LEVEL2;
        end
        rsp_next.sending = state_next.send_request;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (cmd_ready)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (step_fire)
            begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (step_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `ASSERT_ALWAYS(a_error_tracks_safe,
        (state_reg.mode == MODE_ERROR) == !state_reg.safe,
        "error mode out of step with protect fault")
    `ASSERT_ALWAYS(a_code_needs_send,
        !state_reg.code_timing || state_reg.send_request,
        "code timing without a pending send")
    `ASSERT_ALWAYS(a_zero_level_code,
        !rsp_valid_reg || (rsp_reg.power_level != 6'd0) || (rsp_reg.drive_code == 8'h00),
        "nonzero drive code at level zero")
    `ASSERT_NEXT(a_step_shows, step_fire, rsp_valid_reg, "step result not presented")

endmodule

// ===== tb/pulse_transmitter_mode_controller_test.sv =====
module pulse_transmitter_mode_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptmc_pkg::*;

    localparam int LONG_STALL  = 64;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 8;
    localparam int PHASE_BEATS = 40;

    localparam logic [7:0] LEVEL_CODES [32] = '{
        8'h00, 8'h80, 8'h01, 8'h81, 8'h04, 8'h03, 8'h05, 8'h85,
        8'h08, 8'h88, 8'h10, 8'h90, 8'h11, 8'h91, 8'h14, 8'h8d,
        8'h20, 8'ha0, 8'h18, 8'ha1, 8'h40, 8'hc0, 8'h25, 8'hc1,
        8'h44, 8'hc4, 8'h45, 8'ha9, 8'h31, 8'h31, 8'h31, 8'h31
    };

    typedef struct packed {
        ptmc_in_t   beat;
        logic [7:0] reps;
        logic       typed;
        ptmc_out_t  rsp;
    } directed_row_t;

    localparam ptmc_in_t TICK_HIGH = '{OP_TICK, KEY_NONE, PRESS_SHORT, 1'b1};
    localparam ptmc_in_t TICK_LOW  = '{OP_TICK, KEY_NONE, PRESS_SHORT, 1'b0};

    localparam ptmc_out_t AT_RESET =
        '{1'b0, MODE_POWER, 6'd1, 8'h00, FREQ_ONE, PERIOD_LEVEL1, 1'b0};
    localparam ptmc_out_t AT_TOP =
        '{1'b0, MODE_POWER, LEVEL_MAX, 8'h31, FREQ_ONE, PERIOD_LEVEL1, 1'b0};
    localparam ptmc_out_t AT_OFF =
        '{1'b0, MODE_POWER, 6'd0, 8'h00, FREQ_ONE, PERIOD_LEVEL1, 1'b0};
    localparam ptmc_out_t IN_FREQ =
        '{1'b0, MODE_FREQ, 6'd1, 8'h00, FREQ_ONE, PERIOD_LEVEL1, 1'b0};
    localparam ptmc_out_t FREQ_FLIPPED =
        '{1'b0, MODE_FREQ, 6'd1, 8'h00, FREQ_TWO, PERIOD_LEVEL1, 1'b0};

    localparam directed_row_t DIRECTED_ROWS [27] = '{
        '{TICK_HIGH, 8'd1, 1'b1, AT_RESET},
        '{'{OP_KEY, KEY_NONE, PRESS_SHORT, 1'b0}, 8'd1, 1'b1, AT_RESET},
        '{'{OP_KEY, KEY_A, 2'd3, 1'b1}, 8'd1, 1'b1, AT_RESET},
        '{'{OP_KEY, KEY_AB, PRESS_SHORT, 1'b0}, 8'd1, 1'b1, AT_RESET},
        '{'{OP_KEY, KEY_A, PRESS_SHORT, 1'b0}, 8'd33, 1'b0, '0},
        '{'{OP_KEY, KEY_A, PRESS_SHORT, 1'b1}, 8'd1, 1'b1, AT_TOP},
        '{'{OP_KEY, KEY_B, PRESS_SHORT, 1'b0}, 8'd32, 1'b0, '0},
        '{'{OP_KEY, KEY_B, PRESS_SHORT, 1'b1}, 8'd1, 1'b1, AT_OFF},
        '{TICK_LOW, 8'd3, 1'b0, '0},
        '{TICK_LOW, 8'd1, 1'b1, AT_OFF},
        '{'{OP_KEY, KEY_A, PRESS_SHORT, 1'b0}, 8'd1, 1'b1, AT_RESET},
        '{'{OP_KEY, KEY_AB, PRESS_VLONG, 1'b1}, 8'd1, 1'b1, IN_FREQ},
        '{'{OP_KEY, KEY_A, PRESS_SHORT, 1'b0}, 8'd1, 1'b1, FREQ_FLIPPED},
        '{'{OP_KEY, KEY_A, PRESS_VLONG, 1'b0}, 8'd1, 1'b0, '0},
        '{'{OP_KEY, KEY_A, PRESS_SHORT, 1'b1}, 8'd1, 1'b1, IN_FREQ},
        '{'{OP_KEY, KEY_B, PRESS_SHORT, 1'b0}, 8'd1, 1'b0, '0},
        '{TICK_HIGH, 8'd35, 1'b0, '0},
        '{TICK_HIGH, 8'd5, 1'b0, '0},
        '{'{OP_KEY, KEY_AB, PRESS_LONG, 1'b0}, 8'd1, 1'b0, '0},
        '{'{OP_KEY, KEY_A, PRESS_SHORT, 1'b1}, 8'd1, 1'b0, '0},
        '{TICK_HIGH, 8'd10, 1'b0, '0},
        '{'{OP_KEY, KEY_B, PRESS_SHORT, 1'b0}, 8'd1, 1'b0, '0},
        '{TICK_LOW, 8'd150, 1'b0, '0},
        '{TICK_LOW, 8'd4, 1'b0, '0},
        '{'{OP_KEY, KEY_AB, PRESS_LONG, 1'b1}, 8'd1, 1'b0, '0},
        '{TICK_HIGH, 8'd250, 1'b0, '0},
        '{TICK_HIGH, 8'd60, 1'b0, '0}
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    ptmc_in_t  cmd = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    ptmc_out_t rsp;

    ptmc_out_t expected_rsp [$];
    int        beats_in = 0;
    int        beats_out = 0;
    int        mismatches = 0;
    int        cmd_gap_pct = 17;
    int        rsp_stall_pct = 48;
    int        stall_requests = 0;
    int        stalls_served = 0;

    // controller state as the predictor sees it
    mode_t       ctl_mode = MODE_POWER;
    logic [5:0]  ctl_level = 6'd1;
    logic [1:0]  ctl_freq_sel = FREQ_ONE;
    logic [1:0]  ctl_freq_active = FREQ_ONE;
    logic        ctl_enable = 1'b1;
    logic        ctl_send = 1'b0;
    logic [2:0]  ctl_step = STEP_START;
    logic        ctl_code_timing = 1'b0;
    logic        ctl_safe = 1'b1;
    logic [15:0] ctl_ticks = 16'd0;
    logic        ctl_switch = 1'b0;

    pulse_transmitter_mode_controller dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic ptmc_out_t step_controller(input ptmc_in_t beat);
        logic [15:0] on_at;
        logic [15:0] off_at;
        logic [15:0] check_at;
        logic [15:0] burst_end;
        ptmc_out_t   next_rsp;
        on_at = '0;
        off_at = '0;
        check_at = '0;
        burst_end = '0;
        if (beat.operation == OP_KEY)
        begin
            case (ctl_mode)
                MODE_POWER:
                begin
                    if (beat.key == KEY_AB)
                    begin
                        if (beat.press == PRESS_LONG)
                            ctl_mode = MODE_ALARM;
                        else if (beat.press == PRESS_VLONG)
                            ctl_mode = MODE_FREQ;
                    end
                    else if (beat.key == KEY_A && beat.press == PRESS_SHORT)
                    begin
                        if (ctl_level < LEVEL_MAX)
                        begin
                            ctl_enable = 1'b1;
                            ctl_level = ctl_level + 6'd1;
                        end
                    end
                    else if (beat.key == KEY_B && beat.press == PRESS_SHORT)
                    begin
                        if (ctl_level >= 6'd1)
                        begin
                            ctl_level = ctl_level - 6'd1;
                            if (ctl_level == 6'd0)
                                ctl_enable = 1'b0;
                        end
                    end
                end
                MODE_FREQ:
                begin
                    if (beat.key == KEY_A && beat.press == PRESS_SHORT)
                        ctl_freq_sel = (ctl_freq_sel == FREQ_ONE) ? FREQ_TWO : FREQ_ONE;
                    else if (beat.key == KEY_B && beat.press == PRESS_SHORT)
                        ctl_mode = MODE_POWER;
                end
                MODE_ALARM:
                begin
                    if (beat.key == KEY_A && beat.press == PRESS_SHORT)
                        ctl_send = 1'b1;
                    else if (beat.key == KEY_B && beat.press == PRESS_SHORT)
                        ctl_mode = MODE_POWER;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (ctl_freq_active != ctl_freq_sel && ctl_ticks == 16'd0)
                ctl_freq_active = ctl_freq_sel;
            if (!ctl_code_timing)
            begin
                if (ctl_freq_active == FREQ_ONE)
                begin
                    on_at = L1_ON;
                    off_at = L1_OFF;
                    check_at = L1_CHECK;
                    burst_end = L1_BURST;
                end
                else
                begin
                    on_at = L2_ON;
                    off_at = L2_OFF;
                    check_at = L2_CHECK;
                    burst_end = L2_BURST;
                end
            end
            if (!ctl_enable)
            begin
                ctl_switch = 1'b0;
                ctl_ticks = '0;
            end
            else if (ctl_mode != MODE_ALARM)
            begin
                ctl_ticks = ctl_ticks + 16'd1;
                if (ctl_ticks == on_at)
                    ctl_switch = 1'b0;
                if (ctl_ticks == off_at)
                begin
                    ctl_ticks = '0;
                    ctl_switch = 1'b1;
                end
                if (ctl_ticks == check_at)
                    ctl_safe = beat.protect_level;
            end
            else if (!ctl_send)
            begin
                ctl_switch = 1'b0;
                ctl_ticks = '0;
                ctl_step = STEP_START;
            end
            else
            begin
                case (ctl_step)
                    STEP_START, STEP_BURST:
                    begin
                        if (ctl_step == STEP_START)
                        begin
                            ctl_switch = 1'b1;
                            ctl_step = STEP_BURST;
                        end
                        if (ctl_ticks == burst_end)
                        begin
                            ctl_ticks = '0;
                            ctl_switch = 1'b0;
                            ctl_step = STEP_STOP_ARM;
                            ctl_code_timing = 1'b1;
                        end
                    end
                    STEP_STOP_ARM:
                    begin
                        ctl_switch = 1'b0;
                        ctl_step = STEP_STOP;
                        ctl_ticks = '0;
                    end
                    STEP_STOP:
                    begin
                        if (ctl_ticks == STOP_TICKS)
                            ctl_step = STEP_CODE_ARM;
                    end
                    STEP_CODE_ARM:
                    begin
                        ctl_switch = 1'b1;
                        ctl_step = STEP_CODE;
                        ctl_ticks = '0;
                    end
                    STEP_CODE:
                    begin
                        if (ctl_ticks == CODE_TICKS)
                        begin
                            ctl_ticks = '0;
                            ctl_switch = 1'b0;
                            ctl_send = 1'b0;
                            ctl_step = STEP_START;
                            ctl_code_timing = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                ctl_ticks = ctl_ticks + 16'd1;
            end
        end

        if (!ctl_safe)
            ctl_mode = MODE_ERROR;
        else if (ctl_mode == MODE_ERROR)
            ctl_mode = MODE_POWER;

        next_rsp.signal_switch = ctl_switch;
        next_rsp.mode = ctl_mode;
        next_rsp.power_level = ctl_level;
        if (ctl_level == 6'd0)
            next_rsp.drive_code = 8'h00;
        else if (ctl_level > 6'd32)
            next_rsp.drive_code = LEVEL_CODES[31];
        else
            next_rsp.drive_code = LEVEL_CODES[ctl_level - 6'd1];
        next_rsp.freq_level = ctl_freq_sel;
        if (ctl_code_timing)
            next_rsp.period_select = PERIOD_CODE;
        else if (ctl_freq_active == FREQ_ONE)
            next_rsp.period_select = PERIOD_LEVEL1;
        else
            next_rsp.period_select = PERIOD_LEVEL2;
        next_rsp.sending = ctl_send;
        return next_rsp;
    endfunction

    function automatic ptmc_in_t any_beat();
        ptmc_in_t beat;
        beat.operation = 1'($urandom_range(1));
        beat.key = 2'($urandom_range(3));
        beat.press = 2'($urandom_range(3));
        beat.protect_level = 1'($urandom_range(1));
        return beat;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("%0t: rsp beat %0d %s got %0h want %0h", $time, beats_out, what, got,
                 want);
    endtask

    // entered and left at a falling edge
    task automatic send_beat(input ptmc_in_t beat, input logic typed,
                             input ptmc_out_t typed_rsp);
        ptmc_out_t predicted;
        while ($urandom_range(99) < cmd_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= beat;
        do
            @(posedge clk);
        while (!cmd_ready);
        predicted = step_controller(beat);
        expected_rsp.push_back(typed ? typed_rsp : predicted);
        beats_in++;
        @(negedge clk);
    endtask

    task automatic press_key(input logic [1:0] key, input logic [1:0] press);
        ptmc_in_t beat;
        beat = any_beat();
        beat.operation = OP_KEY;
        beat.key = key;
        beat.press = press;
        send_beat(beat, 1'b0, '0);
    endtask

    task automatic tick_run(input int count, input int low_pct);
        ptmc_in_t beat;
        repeat (count)
        begin
            beat = any_beat();
            beat.operation = OP_TICK;
            beat.protect_level = ($urandom_range(99) >= low_pct);
            send_beat(beat, 1'b0, '0);
        end
    endtask

    task automatic enter_power_mode();
        while (ctl_mode != MODE_POWER || !ctl_enable)
        begin
            if (ctl_mode == MODE_ERROR)
                tick_run(1, 0);
            else if (ctl_mode != MODE_POWER)
                press_key(KEY_B, PRESS_SHORT);
            else
                press_key(KEY_A, PRESS_SHORT);
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = beats_in + count;
        while (beats_in < stop_at)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    enter_power_mode();
                    repeat ($urandom_range(4, 1))
                        press_key(($urandom_range(2) != 0) ? KEY_A : KEY_B, PRESS_SHORT);
                end
                2, 3, 4:
                    tick_run($urandom_range(30, 1), ($urandom_range(1) != 0) ? 0 : 40);
                5:
                begin
                    enter_power_mode();
                    press_key(KEY_AB, PRESS_VLONG);
                    repeat ($urandom_range(3))
                        press_key(KEY_A, PRESS_SHORT);
                    if ($urandom_range(1) != 0)
                        tick_run($urandom_range(20, 1), 10);
                    press_key(KEY_B, PRESS_SHORT);
                end
                6:
                begin
                    enter_power_mode();
                    press_key(KEY_AB, PRESS_LONG);
                    tick_run($urandom_range(20, 1), 20);
                    press_key(KEY_B, PRESS_SHORT);
                end
                7:
                    repeat ($urandom_range(6, 1))
                        send_beat(any_beat(), 1'b0, '0);
                8:
                    press_key(2'($urandom_range(3)), 2'($urandom_range(3)));
                default:
                    tick_run($urandom_range(20, 1), 50);
            endcase
        end
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stalls_served != stall_requests)
            begin
                stalls_served = stall_requests;
                rsp_ready <= 1'b0;
                repeat (LONG_STALL) @(negedge clk);
            end
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial
    begin
        ptmc_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                beats_out++;
                if (expected_rsp.size() == 0)
                begin
                    report_mismatch("unexpected beat", 16'(rsp), 16'd0);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.signal_switch !== want.signal_switch)
                        report_mismatch("signal_switch", 16'(rsp.signal_switch),
                                        16'(want.signal_switch));
                    if (rsp.mode !== want.mode)
                        report_mismatch("mode", 16'(rsp.mode), 16'(want.mode));
                    if (rsp.power_level !== want.power_level)
                        report_mismatch("power_level", 16'(rsp.power_level),
                                        16'(want.power_level));
                    if (rsp.drive_code !== want.drive_code)
                        report_mismatch("drive_code", 16'(rsp.drive_code),
                                        16'(want.drive_code));
                    if (rsp.freq_level !== want.freq_level)
                        report_mismatch("freq_level", 16'(rsp.freq_level),
                                        16'(want.freq_level));
                    if (rsp.period_select !== want.period_select)
                        report_mismatch("period_select", 16'(rsp.period_select),
                                        16'(want.period_select));
                    if (rsp.sending !== want.sending)
                        report_mismatch("sending", 16'(rsp.sending), 16'(want.sending));
                end
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
            repeat (DIRECTED_ROWS[i].reps)
                send_beat(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed,
                          DIRECTED_ROWS[i].rsp);

        stall_requests++;
        run_random(PHASE_BEATS);

        cmd_gap_pct = 48;
        rsp_stall_pct = 17;
        run_random(PHASE_BEATS);

        cmd_gap_pct = 0;
        rsp_stall_pct = 0;
        stall_requests++;
        run_random(PHASE_BEATS);

        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== pulse_transmitter_mode_controller.f =====
+incdir+rtl/core
rtl/core/ptmc_pkg.sv
rtl/core/ptmc_key_fsm.sv
rtl/core/ptmc_pulse_timer.sv
rtl/core/pulse_transmitter_mode_controller.sv
tb/pulse_transmitter_mode_controller_test.sv
